// ===== rtl/core/cfc_pkg.sv =====
// types and constants shared by the colour sensor reader
`timescale 1ns / 1ps
`default_nettype none

package cfc_pkg;

    localparam logic [1:0] FILTER_RED   = 2'd0;
    localparam logic [1:0] FILTER_BLUE  = 2'd1;
    localparam logic [1:0] FILTER_GREEN = 2'd3;

    localparam logic [2:0] KIND_NONE  = 3'd0;
    localparam logic [2:0] KIND_RED   = 3'd1;
    localparam logic [2:0] KIND_BLUE  = 3'd2;
    localparam logic [2:0] KIND_GREEN = 3'd3;
    localparam logic [2:0] KIND_CLASS = 3'd4;

    localparam logic [2:0] CLASS_RED     = 3'd0;
    localparam logic [2:0] CLASS_BLUE    = 3'd1;
    localparam logic [2:0] CLASS_YELLOW  = 3'd2;
    localparam logic [2:0] CLASS_GREEN   = 3'd3;
    localparam logic [2:0] CLASS_UNKNOWN = 3'd4;

    localparam logic [1:0] PHASE_RED   = 2'd0;
    localparam logic [1:0] PHASE_BLUE  = 2'd1;
    localparam logic [1:0] PHASE_GREEN = 2'd2;
    localparam logic [1:0] PHASE_CLASS = 2'd3;

    localparam logic [15:0] WINDOW_RESET = 16'd20000;
    localparam logic [9:0]  DISP_MAX     = 10'd999;

    // window result before digit split
    typedef struct packed {
        logic [1:0]  filter_select;
        logic [2:0]  report_kind;
        logic [15:0] window_count;
        logic [9:0]  disp_value;
        logic        digits_saturated;
        logic [2:0]  colour_class;
    } win_rec_t;

    // result as presented on the output channel
    typedef struct packed {
        logic [1:0]  filter_select;
        logic [2:0]  report_kind;
        logic [15:0] window_count;
        logic [3:0]  hundreds_digit;
        logic [3:0]  tens_digit;
        logic [3:0]  ones_digit;
        logic        digits_saturated;
        logic [2:0]  colour_class;
    } result_t;

endpackage

`default_nettype wire

// ===== rtl/core/cfc_window_ctrl.sv =====
// window counting, filter sequencing and colour classification stage
`timescale 1ns / 1ps
`default_nettype none

module cfc_window_ctrl #(
    parameter int COUNT_WIDTH = 16
) (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              cfg_wr_en,
    input  wire [15:0]       cfg_wr_data,
    input  wire              in_valid,
    output logic             in_ready,
    input  wire              in_pulse,
    input  wire              in_tick,
    output logic             rec_valid,
    input  wire              rec_ready,
    output cfc_pkg::win_rec_t rec
);
    import cfc_pkg::*;

    logic [15:0]            window_length_reg;
    logic [COUNT_WIDTH-1:0] pulse_total_reg, pulse_total_next, pulse_inc;
    logic [15:0]            tick_total_reg, tick_total_next, tick_inc;
    logic [1:0]             phase_reg, phase_next;
    logic [7:0]             red_level_reg, red_level_next;
    logic [7:0]             blue_level_reg, blue_level_next;
    logic [7:0]             green_level_reg, green_level_next;
    logic [1:0]             filter_reg, filter_next;
    logic                   rec_valid_reg;
    win_rec_t               rec_reg, rec_next;
    logic [15:0]            limit;
    logic                   window_end;
    logic [31:0]            cnt_ext;
    logic [2:0]             cls;
    logic [9:0]             r, b, g;
    logic                   accept;

    assign in_ready  = !rec_valid_reg || rec_ready;
    assign accept    = in_valid && in_ready;
    assign rec_valid = rec_valid_reg;
    assign rec       = rec_reg;

    assign pulse_inc  = in_pulse ? pulse_total_reg + 1'b1 : pulse_total_reg;
    assign tick_inc   = tick_total_reg + 16'd1;
    assign limit      = (window_length_reg == 16'd0) ? 16'd1 : window_length_reg;
    assign window_end = in_tick && (tick_inc >= limit);
    assign cnt_ext    = 32'(pulse_inc);

    assign r = {2'b00, red_level_reg};
    assign b = {2'b00, blue_level_reg};
    assign g = {2'b00, green_level_reg};

    // priority order: red, blue, yellow, green
    always_comb begin
        if (r + 10'd5 > b + g) begin
            cls = CLASS_RED;
        end else if ((b + 10'd8 > r) && (b + 10'd2 > g)) begin
            cls = CLASS_BLUE;
        end else if ((g < r + 10'd3) && (g > b + 10'd15)) begin
            cls = CLASS_YELLOW;
        end else if ((g + 10'd5 > r) && (g > b)) begin
            cls = CLASS_GREEN;
        end else begin
            cls = CLASS_UNKNOWN;
        end
    end

    always_comb begin
        pulse_total_next = pulse_inc;
        tick_total_next  = in_tick ? tick_inc : tick_total_reg;
        phase_next       = phase_reg;
        red_level_next   = red_level_reg;
        blue_level_next  = blue_level_reg;
        green_level_next = green_level_reg;
        filter_next      = filter_reg;
        rec_next         = '0;
        if (window_end) begin
            pulse_total_next = '0;
            tick_total_next  = '0;
            if (phase_reg == PHASE_CLASS) begin
                rec_next.report_kind  = KIND_CLASS;
                rec_next.colour_class = cls;
                phase_next            = PHASE_RED;
            end else begin
                rec_next.window_count     = (cnt_ext > 32'h0000_FFFF) ? 16'hFFFF
                                                                      : cnt_ext[15:0];
                rec_next.digits_saturated = (cnt_ext > 32'd999);
                rec_next.disp_value       = (cnt_ext > 32'd999) ? DISP_MAX : cnt_ext[9:0];
                phase_next                = phase_reg + 2'd1;
                case (phase_reg)
                    PHASE_RED: begin
                        rec_next.report_kind = KIND_RED;
                        red_level_next       = pulse_inc[7:0];
                        filter_next          = FILTER_BLUE;
                    end
                    PHASE_BLUE: begin
                        rec_next.report_kind = KIND_BLUE;
                        blue_level_next      = pulse_inc[7:0];
                        filter_next          = FILTER_GREEN;
                    end
                    default: begin
                        rec_next.report_kind = KIND_GREEN;
                        green_level_next     = pulse_inc[7:0];
                        filter_next          = FILTER_RED;
                    end
                endcase
            end
        end
        rec_next.filter_select = filter_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_length_reg <= WINDOW_RESET;
        end else if (cfg_wr_en) begin
            window_length_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pulse_total_reg <= '0;
            tick_total_reg  <= '0;
            phase_reg       <= PHASE_RED;
            red_level_reg   <= '0;
            blue_level_reg  <= '0;
            green_level_reg <= '0;
            filter_reg      <= FILTER_RED;
        end else if (accept) begin
            pulse_total_reg <= pulse_total_next;
            tick_total_reg  <= tick_total_next;
            phase_reg       <= phase_next;
            red_level_reg   <= red_level_next;
            blue_level_reg  <= blue_level_next;
            green_level_reg <= green_level_next;
            filter_reg      <= filter_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rec_valid_reg <= 1'b0;
        end else if (in_ready) begin
            rec_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            rec_reg <= rec_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/cfc_digit_split.sv =====
// splits a count of at most 999 into three decimal digits
`timescale 1ns / 1ps
`default_nettype none

module cfc_digit_split (
    input  wire cfc_pkg::win_rec_t rec,
    output cfc_pkg::result_t       res
);
    import cfc_pkg::*;

    logic [15:0] hund_prod;
    logic [3:0]  hund;
    logic [9:0]  hund_part;
    logic [6:0]  rem100;
    logic [14:0] tens_prod;
    logic [3:0]  tens;
    logic [6:0]  tens_part;
    logic [6:0]  ones_wide;

    // x / 100 == (x * 41) >> 12 for x below 1000
    assign hund_prod = 16'(rec.disp_value) * 16'd41;
    assign hund      = hund_prod[15:12];
    assign hund_part = 10'(hund) * 10'd100;
    assign rem100    = 7'(rec.disp_value - hund_part);
    // x / 10 == (x * 205) >> 11 for x below 100
    assign tens_prod = 15'(rem100) * 15'd205;
    assign tens      = tens_prod[14:11];
    assign tens_part = 7'(tens) * 7'd10;
    assign ones_wide = rem100 - tens_part;

    always_comb begin
        res.filter_select    = rec.filter_select;
        res.report_kind      = rec.report_kind;
        res.window_count     = rec.window_count;
        res.hundreds_digit   = hund;
        res.tens_digit       = tens;
        res.ones_digit       = ones_wide[3:0];
        res.digits_saturated = rec.digits_saturated;
        res.colour_class     = rec.colour_class;
    end

endmodule

`default_nettype wire

// ===== rtl/core/cfc_skid_buffer.sv =====
// output register with skid entry so the request side sees a registered ready
`timescale 1ns / 1ps
`default_nettype none

module cfc_skid_buffer (
    input  wire              aclk,
    input  wire              aresetn,
    input  wire              in_valid,
    output logic             in_ready,
    input  wire cfc_pkg::result_t in_data,
    output logic             out_valid,
    input  wire              out_ready,
    output cfc_pkg::result_t out_data
);
    import cfc_pkg::*;

    logic    out_valid_reg;
    logic    skid_valid_reg;
    result_t out_data_reg;
    result_t skid_data_reg;
    logic    in_fire;

    assign in_ready  = !skid_valid_reg;
    assign in_fire   = in_valid && !skid_valid_reg;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else if (out_ready || !out_valid_reg) begin
            if (skid_valid_reg) begin
                skid_valid_reg <= 1'b0;
            end else begin
                out_valid_reg <= in_fire;
            end
        end else if (in_fire) begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_ready || !out_valid_reg) begin
            if (skid_valid_reg) begin
                out_data_reg <= skid_data_reg;
            end else if (in_fire) begin
                out_data_reg <= in_data;
            end
        end else if (in_fire) begin
            skid_data_reg <= in_data;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/rgb_pulse_color_classifier_unit.sv =====
// top level of the light-to-frequency colour sensor reader
// usage:
//   the input channel (s_valid/s_ready) carries one request per clock while
//   s_ready is high, with the pulse and tick flags; every accepted request
//   gives exactly one result on the output channel (m_valid/m_ready).
//   windows of window_length ticks run red, blue, green, then a classify
//   window; count windows report the count and three digits, the classify
//   window reports the colour class. m_filter_select drives the sensor filter.
//   the window length register is written through cfg_wr_en/cfg_wr_data with
//   no wait state; a length of zero acts as one.
// timing:
//   a result is registered by the single counting stage, goes through the digit
//   split and is registered again by the output register with one skid entry;
//   one request is taken every cycle while s_ready is high.
// reset and stall:
//   synchronous active-low reset clears counters, levels and the filter to red
//   and sets the window length to 20000. when the receiver stalls, up to three
//   results are held (stage, output and skid registers) before s_ready falls;
//   nothing is dropped.
`timescale 1ns / 1ps
`default_nettype none

module rgb_pulse_color_classifier_unit #(
    parameter int COUNT_WIDTH = 16
) (
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         cfg_wr_en,
    input  wire  [15:0] cfg_wr_data,
    input  wire         s_valid,
    output logic        s_ready,
    input  wire         s_pulse,
    input  wire         s_tick,
    output logic        m_valid,
    input  wire         m_ready,
    output logic [1:0]  m_filter_select,
    output logic [2:0]  m_report_kind,
    output logic [15:0] m_window_count,
    output logic [3:0]  m_hundreds_digit,
    output logic [3:0]  m_tens_digit,
    output logic [3:0]  m_ones_digit,
    output logic        m_digits_saturated,
    output logic [2:0]  m_colour_class
);
    import cfc_pkg::*;

    logic     rec_valid;
    logic     rec_ready;
    win_rec_t rec;
    result_t  res;
    result_t  out_res;

    cfc_window_ctrl #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_window_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (s_valid),
        .in_ready    (s_ready),
        .in_pulse    (s_pulse),
        .in_tick     (s_tick),
        .rec_valid   (rec_valid),
        .rec_ready   (rec_ready),
        .rec         (rec)
    );

    cfc_digit_split u_digit_split (
        .rec (rec),
        .res (res)
    );

    cfc_skid_buffer u_skid_buffer (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (rec_valid),
        .in_ready  (rec_ready),
        .in_data   (res),
        .out_valid (m_valid),
        .out_ready (m_ready),
        .out_data  (out_res)
    );

    assign m_filter_select    = out_res.filter_select;
    assign m_report_kind      = out_res.report_kind;
    assign m_window_count     = out_res.window_count;
    assign m_hundreds_digit   = out_res.hundreds_digit;
    assign m_tens_digit       = out_res.tens_digit;
    assign m_ones_digit       = out_res.ones_digit;
    assign m_digits_saturated = out_res.digits_saturated;
    assign m_colour_class     = out_res.colour_class;

endmodule

`default_nettype wire
